// ===== rtl/md5_digest_engine_assert.svh =====
// Assertion macros used by the MD5 digest engine RTL.
`ifndef MD5_DIGEST_ENGINE_ASSERT_SVH
`define MD5_DIGEST_ENGINE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define MD5DE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define MD5DE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/md5de_pkg.sv =====
// Types, constants and helper functions of the MD5 digest engine.
`default_nettype none

package md5de_pkg;

    typedef logic [31:0] t_word;
    typedef t_word [3:0] t_quad;

    // Initial chaining values A, B, C, D.
    localparam t_word IV_A = 32'h6745_2301;
    localparam t_word IV_B = 32'hEFCD_AB89;
    localparam t_word IV_C = 32'h98BA_DCFE;
    localparam t_word IV_D = 32'h1032_5476;
    localparam t_quad IV_QUAD = {IV_D, IV_C, IV_B, IV_A};

    // Round groups, taken from the upper two bits of the round number.
    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;
    localparam logic [1:0] GRP_I = 2'd3;

    localparam t_word K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by {group, round[1:0]}.
    localparam logic [4:0] ROT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Control from the sequencer to the compression unit.
    typedef struct packed {
        logic start;
    } t_cmp_ctrl;

    // Status from the compression unit back to the sequencer.
    typedef struct packed {
        logic       busy;
        logic       done;
        logic [3:0] msg_idx;
    } t_cmp_stat;

    // Message word used by a given round.
    function automatic logic [3:0] md5_msg_idx(input logic [5:0] rnd);
        logic [3:0] r;
        logic [3:0] k;
        r = rnd[3:0];
        case (rnd[5:4])
            GRP_F:   k = r;
            GRP_G:   k = 4'(r * 4'd5 + 4'd1);
            GRP_H:   k = 4'(r * 4'd3 + 4'd5);
            GRP_I:   k = 4'(r * 4'd7);
            default: k = r;
        endcase
        return k;
    endfunction

    function automatic t_word bswap32(input t_word v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/md5de_compress.sv =====
// MD5 compression unit: one round per cycle on shared round logic.
`default_nettype none

module md5de_compress (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  md5de_pkg::t_cmp_ctrl    i_ctrl,
    input  md5de_pkg::t_quad        i_chain,
    input  md5de_pkg::t_word        i_msg_word,
    output md5de_pkg::t_cmp_stat    o_stat,
    output md5de_pkg::t_quad        o_regs
);

    md5de_pkg::t_quad r_regs;
    logic [5:0]       r_rnd;
    logic             r_busy;
    logic             r_done;

    md5de_pkg::t_word w_a, w_b, w_c, w_d, w_f, w_sum, w_rot, w_bnew;
    logic [63:0]      w_dbl;
    logic [4:0]       w_sh;

    assign w_a = r_regs[0];
    assign w_b = r_regs[1];
    assign w_c = r_regs[2];
    assign w_d = r_regs[3];

    always_comb begin
        case (r_rnd[5:4])
            md5de_pkg::GRP_F: w_f = (w_b & w_c) | (~w_b & w_d);
            md5de_pkg::GRP_G: w_f = (w_b & w_d) | (w_c & ~w_d);
            md5de_pkg::GRP_H: w_f = w_b ^ w_c ^ w_d;
            md5de_pkg::GRP_I: w_f = w_c ^ (w_b | ~w_d);
            default:          w_f = w_b ^ w_c ^ w_d;
        endcase
    end

    assign w_sum  = w_f + w_a + i_msg_word + md5de_pkg::K_TAB[r_rnd];
    assign w_sh   = md5de_pkg::ROT_TAB[{r_rnd[5:4], r_rnd[1:0]}];
    assign w_dbl  = {w_sum, w_sum} << w_sh;
    assign w_rot  = w_dbl[63:32];
    assign w_bnew = w_b + w_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_regs <= i_chain;
        end else if (r_busy) begin
            r_regs <= {w_c, w_b, w_bnew, w_d};
        end
    end

    assign o_stat.busy    = r_busy;
    assign o_stat.done    = r_done;
    assign o_stat.msg_idx = md5de_pkg::md5_msg_idx(r_rnd);
    assign o_regs         = r_regs;

endmodule

`default_nettype wire

// ===== rtl/md5_digest_engine.sv =====
// Top level of the MD5 digest engine: word intake, padding sequencer and digest output.
//
//  Channel   Dir  Fields (tdata / tuser / tlast)                     Width
//  s_axis    in   msg_word / byte_count / last_word                  32 / 3 / 1
//  m_axis    out  digest_part / - / final_part                       64 / - / 1
//
// Message words are taken one per cycle, while the intake is open, into a 16-word
// block buffer. Each full block then stalls the intake: the sequencer starts the
// compression unit, which runs all rounds on its single round datapath, and then
// folds the result into the chaining value. After the last word the padding words
// are pushed one per cycle, with one or two compressions, and the digest is handed
// to an output register that drains as two transactions.
// Reset is synchronous and active low; the block buffer is not cleared.
// The intake stalls while a compression runs, while padding is pushed and in the
// final state; a stalled output only holds the next digest back once it is complete.
`default_nettype none
`include "md5_digest_engine_assert.svh"

module md5_digest_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] msg_word
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] byte_count
    input  logic        i_s_axis_tlast,   // last_word
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] digest_part
    output logic        o_m_axis_tlast    // final_part
);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_COMP = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    // Padding phases: the marker word (only after a full final word), the zero
    // fill up to slot 14, the high length word, and the end of padding.
    typedef enum logic [3:0] {
        PH_MARK = 4'b0001,
        PH_ZERO = 4'b0010,
        PH_LHI  = 4'b0100,
        PH_END  = 4'b1000
    } t_phase;

    localparam logic [2:0] BYTES_FULL = 3'd4;

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic                r_pad_run, n_pad_run;
    logic [3:0]          r_wp, n_wp;
    logic [63:0]         r_bitlen, n_bitlen;
    md5de_pkg::t_quad    r_chain, n_chain;
    logic                r_start, n_start;
    logic                r_out_valid, n_out_valid;
    logic                r_out_part, n_out_part;
    logic [63:0]         r_dig0, r_dig1;
    md5de_pkg::t_word    r_buf [16];

    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_push;
    logic                w_load;
    md5de_pkg::t_word    w_push_word;
    md5de_pkg::t_word    w_first_word;
    logic [2:0]          w_nbytes;
    md5de_pkg::t_cmp_ctrl w_ctrl;
    md5de_pkg::t_cmp_stat w_stat;
    md5de_pkg::t_quad    w_regs;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc       = r_out_valid && i_m_axis_tready;

    // Byte counts above four on the final word count as four.
    assign w_nbytes = (i_s_axis_tuser > BYTES_FULL) ? BYTES_FULL : i_s_axis_tuser;

    // Final word with its valid bytes kept and the 0x80 marker placed after them.
    always_comb begin
        case (w_nbytes)
            3'd0:    w_first_word = 32'h0000_0080;
            3'd1:    w_first_word = {16'h0000, 8'h80, i_s_axis_tdata[7:0]};
            3'd2:    w_first_word = {8'h00, 8'h80, i_s_axis_tdata[15:0]};
            3'd3:    w_first_word = {8'h80, i_s_axis_tdata[23:0]};
            default: w_first_word = i_s_axis_tdata;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_pad_run   = r_pad_run;
        n_wp        = r_wp;
        n_bitlen    = r_bitlen;
        n_chain     = r_chain;
        n_start     = 1'b0;
        n_out_valid = r_out_valid;
        n_out_part  = r_out_part;
        w_push      = 1'b0;
        w_push_word = '0;
        w_load      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    w_push = 1'b1;
                    if (!i_s_axis_tlast) begin
                        w_push_word = i_s_axis_tdata;
                        n_bitlen    = r_bitlen + 64'd32;
                    end else begin
                        w_push_word = w_first_word;
                        n_bitlen    = r_bitlen + {58'd0, w_nbytes, 3'b000};
                        n_pad_run   = 1'b1;
                        n_phase     = (w_nbytes == BYTES_FULL) ? PH_MARK : PH_ZERO;
                        n_state     = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                w_push = 1'b1;
                case (r_phase)
                    PH_MARK: begin
                        w_push_word = 32'h0000_0080;
                        n_phase     = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (r_wp == 4'd14) begin
                            w_push_word = r_bitlen[31:0];
                            n_phase     = PH_LHI;
                        end else begin
                            w_push_word = '0;
                        end
                    end
                    PH_LHI: begin
                        w_push_word = r_bitlen[63:32];
                        n_phase     = PH_END;
                    end
                    default: begin
                        w_push  = 1'b0;
                        n_state = ST_FIN;
                    end
                endcase
            end
            ST_COMP: begin
                if (w_stat.done) begin
                    for (int i = 0; i < 4; i++) begin
                        n_chain[i] = r_chain[i] + w_regs[i];
                    end
                    if (!r_pad_run) begin
                        n_state = ST_IDLE;
                    end else if (r_phase == PH_END) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_FIN: begin
                // Wait until the previous digest has fully drained.
                if (!r_out_valid) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_part  = 1'b0;
                    n_chain     = md5de_pkg::IV_QUAD;
                    n_bitlen    = '0;
                    n_wp        = '0;
                    n_pad_run   = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Every pushed word advances the slot; the sixteenth starts a compression.
        if (w_push) begin
            n_wp = r_wp + 4'd1;
            if (r_wp == 4'd15) begin
                n_state = ST_COMP;
                n_start = 1'b1;
            end
        end

        if (w_out_acc) begin
            if (!r_out_part) begin
                n_out_part = 1'b1;
            end else begin
                n_out_valid = 1'b0;
                n_out_part  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_END;
            r_pad_run   <= 1'b0;
            r_wp        <= '0;
            r_bitlen    <= '0;
            r_chain     <= md5de_pkg::IV_QUAD;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_part  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pad_run   <= n_pad_run;
            r_wp        <= n_wp;
            r_bitlen    <= n_bitlen;
            r_chain     <= n_chain;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            r_out_part  <= n_out_part;
        end
    end

    // Block buffer and digest holding registers carry payload only.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_push_word;
        end
        if (w_load) begin
            r_dig0 <= {md5de_pkg::bswap32(r_chain[0]), md5de_pkg::bswap32(r_chain[1])};
            r_dig1 <= {md5de_pkg::bswap32(r_chain[2]), md5de_pkg::bswap32(r_chain[3])};
        end
    end

    assign w_ctrl.start = r_start;

    md5de_compress u_compress (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_chain    (r_chain),
        .i_msg_word (r_buf[w_stat.msg_idx]),
        .o_stat     (w_stat),
        .o_regs     (w_regs)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_part ? r_dig1 : r_dig0;
    assign o_m_axis_tlast  = r_out_part;

    `MD5DE_ASSERT_SAME(a_ready_not_busy, o_s_axis_tready, !w_stat.busy, "intake open during compression")
    `MD5DE_ASSERT_NEXT(a_start_runs, r_start, w_stat.busy, "compression did not start")
    `MD5DE_ASSERT_SAME(a_done_in_comp, w_stat.done, r_state == ST_COMP, "compression done outside wait state")
    `MD5DE_ASSERT_NEXT(a_fin_loads, (r_state == ST_FIN) && !r_out_valid, r_out_valid && !r_out_part && (r_state == ST_IDLE), "digest not loaded")
    `MD5DE_ASSERT_SAME(a_part_valid, r_out_part, r_out_valid, "second half shown without a digest")

endmodule

`default_nettype wire
